/* hdl/cpl_pkg.sv */
// Shared types, widths and latencies for the closest-points-between-two-lines block.
// No dependencies; every other file but cpl_delay imports this package.
package cpl_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    // Dot products: sum of three 32 x 33 bit products, with headroom
    localparam int DOT_W         = 67;
    // Determinant and numerators: difference of two DOT_W x DOT_W products
    localparam int WIDE_W        = 2 * DOT_W + 1;
    localparam int LIMB_W        = 32;
    localparam int QUO_BITS      = DATA_W;

    // Register stages of each unit
    localparam int DOT_LAT = 3;
    localparam int MUL_LAT = 5;
    localparam int DIV_LAT = QUO_BITS + 3;
    localparam int PT_LAT  = 2;

    typedef logic signed [DATA_W-1:0] fix_t;
    typedef logic signed [DOT_W-1:0]  dot_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        fix_t first_origin_x;
        fix_t first_origin_y;
        fix_t first_origin_z;
        fix_t first_dir_x;
        fix_t first_dir_y;
        fix_t first_dir_z;
        fix_t second_origin_x;
        fix_t second_origin_y;
        fix_t second_origin_z;
        fix_t second_dir_x;
        fix_t second_dir_y;
        fix_t second_dir_z;
    } in_t;

    typedef struct packed {
        fix_t first_param;
        fix_t second_param;
        fix_t first_point_x;
        fix_t first_point_y;
        fix_t first_point_z;
        fix_t second_point_x;
        fix_t second_point_y;
        fix_t second_point_z;
        logic not_parallel;
    } out_t;

    typedef struct packed {
        dot_t a;
        dot_t b;
        dot_t c;
        dot_t d;
        dot_t e;
    } dots_t;

    // Clamp a 65-bit signed sum to the fixed-point range
    function automatic fix_t sat_fix(input logic signed [2*DATA_W:0] v);
        if (v > (2*DATA_W+1)'(FIX_MAX)) begin
            return FIX_MAX;
        end else if (v < (2*DATA_W+1)'(FIX_MIN)) begin
            return FIX_MIN;
        end
        return fix_t'(v);
    endfunction

endpackage

/* hdl/closest_points_two_lines.sv */
// Closest points between two 3D lines in signed fixed point (FRAC_BITS fraction bits).
// Fully pipelined: one line pair is taken per clock while the output is not stalled; the
// depth is set mainly by the divider (35 stages), which resolves one quotient bit per step
// stage, after 3 stages of dot products, 5 of wide multiplication, 2 of determinant
// and case selection, and 2 for the points. The whole pipe halts only while a result is
// held at the output and not taken. No clearing pass after reset; no configuration.
// Depends on cpl_pkg and the cpl_* units.
module closest_points_two_lines import cpl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int LINE_DLY = DOT_LAT + MUL_LAT + 2 + DIV_LAT;
    localparam int LATENCY  = LINE_DLY + PT_LAT;

    logic                     en;
    logic [LATENCY-1:0]       vld_reg;
    dots_t                    dots;
    dots_t                    dots_dly;
    logic signed [2*DOT_W-1:0] ac, bb, be, cd, ae, bd;
    wide_t                    den_reg;
    wide_t                    n1_reg;
    wide_t                    n2_reg;
    dots_t                    dots_reg;
    logic                     par;
    logic                     b_gt_c;
    wide_t                    num1_reg;
    wide_t                    den1_reg;
    wide_t                    num2_reg;
    wide_t                    den2_reg;
    logic                     np_reg;
    logic                     np_dly;
    fix_t                     t1;
    fix_t                     t2;
    logic [$bits(in_t)-1:0]   pair_bits;
    in_t                      pair_dly;

    // Global advance: halt only when the output holds an untaken transaction
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LATENCY-2:0], s_valid};
        end
    end

    assign m_valid = vld_reg[LATENCY-1];

    cpl_dots u_dots (
        .aclk (aclk),
        .en   (en),
        .pair (s_data),
        .dots (dots)
    );

    cpl_wmul #(.WA(DOT_W), .WB(DOT_W)) u_mul_ac (
        .aclk(aclk), .en(en), .a(dots.a), .b(dots.c), .p(ac)
    );
    cpl_wmul #(.WA(DOT_W), .WB(DOT_W)) u_mul_bb (
        .aclk(aclk), .en(en), .a(dots.b), .b(dots.b), .p(bb)
    );
    cpl_wmul #(.WA(DOT_W), .WB(DOT_W)) u_mul_be (
        .aclk(aclk), .en(en), .a(dots.b), .b(dots.e), .p(be)
    );
    cpl_wmul #(.WA(DOT_W), .WB(DOT_W)) u_mul_cd (
        .aclk(aclk), .en(en), .a(dots.c), .b(dots.d), .p(cd)
    );
    cpl_wmul #(.WA(DOT_W), .WB(DOT_W)) u_mul_ae (
        .aclk(aclk), .en(en), .a(dots.a), .b(dots.e), .p(ae)
    );
    cpl_wmul #(.WA(DOT_W), .WB(DOT_W)) u_mul_bd (
        .aclk(aclk), .en(en), .a(dots.b), .b(dots.d), .p(bd)
    );

    // Keep the dot products beside the multipliers
    cpl_delay #(.W($bits(dots_t)), .DEPTH(MUL_LAT)) u_dots_dly (
        .aclk (aclk),
        .en   (en),
        .din  (dots),
        .dout (dots_dly)
    );

    // Determinant and both numerators
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg  <= wide_t'(ac) - wide_t'(bb);
            n1_reg   <= wide_t'(be) - wide_t'(cd);
            n2_reg   <= wide_t'(ae) - wide_t'(bd);
            dots_reg <= dots_dly;
        end
    end

    // Pick the divider operands; t1 falls to zero through its zero divisor when parallel
    assign par    = (den_reg == '0);
    assign b_gt_c = dots_reg.b > dots_reg.c;

    always_ff @(posedge aclk) begin
        if (en) begin
            num1_reg <= n1_reg;
            den1_reg <= den_reg;
            np_reg   <= !par;
            if (!par) begin
                num2_reg <= n2_reg;
                den2_reg <= den_reg;
            end else if (b_gt_c) begin
                num2_reg <= wide_t'(dots_reg.d);
                den2_reg <= wide_t'(dots_reg.b);
            end else begin
                num2_reg <= wide_t'(dots_reg.e);
                den2_reg <= wide_t'(dots_reg.c);
            end
        end
    end

    cpl_div #(.FRAC_BITS(FRAC_BITS)) u_div_t1 (
        .aclk (aclk),
        .en   (en),
        .num  (num1_reg),
        .den  (den1_reg),
        .quo  (t1)
    );

    cpl_div #(.FRAC_BITS(FRAC_BITS)) u_div_t2 (
        .aclk (aclk),
        .en   (en),
        .num  (num2_reg),
        .den  (den2_reg),
        .quo  (t2)
    );

    cpl_delay #(.W(1), .DEPTH(DIV_LAT)) u_np_dly (
        .aclk (aclk),
        .en   (en),
        .din  (np_reg),
        .dout (np_dly)
    );

    // Hold origins and directions until the parameters are ready
    cpl_delay #(.W($bits(in_t)), .DEPTH(LINE_DLY)) u_pair_dly (
        .aclk (aclk),
        .en   (en),
        .din  (s_data),
        .dout (pair_bits)
    );

    assign pair_dly = pair_bits;

    cpl_point #(.FRAC_BITS(FRAC_BITS)) u_point (
        .aclk (aclk),
        .en   (en),
        .pair (pair_dly),
        .t1   (t1),
        .t2   (t2),
        .np   (np_dly),
        .res  (m_data)
    );

endmodule

/* hdl/cpl_delay.sv */
// Generic enabled shift line used to align side data with the arithmetic stages.
// Depends on nothing.
module cpl_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [DEPTH];

    // Advance the line on every enabled cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

/* hdl/cpl_dots.sv */
// Difference of origins and the five dot products a..e, three register stages.
// Depends on cpl_pkg.
module cpl_dots import cpl_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  in_t   pair,
    output dots_t dots
);

    fix_t                       v1_reg [3];
    fix_t                       v2_reg [3];
    logic signed [DATA_W:0]     w_reg  [3];
    logic signed [2*DATA_W-1:0] pa_reg [3];
    logic signed [2*DATA_W-1:0] pb_reg [3];
    logic signed [2*DATA_W-1:0] pc_reg [3];
    logic signed [2*DATA_W:0]   pd_reg [3];
    logic signed [2*DATA_W:0]   pe_reg [3];
    dots_t                      dots_reg;

    fix_t p1 [3];
    fix_t p2 [3];
    fix_t v1 [3];
    fix_t v2 [3];

    assign p1[0] = pair.first_origin_x;
    assign p1[1] = pair.first_origin_y;
    assign p1[2] = pair.first_origin_z;
    assign v1[0] = pair.first_dir_x;
    assign v1[1] = pair.first_dir_y;
    assign v1[2] = pair.first_dir_z;
    assign p2[0] = pair.second_origin_x;
    assign p2[1] = pair.second_origin_y;
    assign p2[2] = pair.second_origin_z;
    assign v2[0] = pair.second_dir_x;
    assign v2[1] = pair.second_dir_y;
    assign v2[2] = pair.second_dir_z;

    // Capture directions and form w = p1 - p2
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                v1_reg[i] <= v1[i];
                v2_reg[i] <= v2[i];
                w_reg[i]  <= (DATA_W+1)'(p1[i]) - (DATA_W+1)'(p2[i]);
            end
        end
    end

    // Element products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pa_reg[i] <= v1_reg[i] * v1_reg[i];
                pb_reg[i] <= v1_reg[i] * v2_reg[i];
                pc_reg[i] <= v2_reg[i] * v2_reg[i];
                pd_reg[i] <= v1_reg[i] * w_reg[i];
                pe_reg[i] <= v2_reg[i] * w_reg[i];
            end
        end
    end

    // Sum the three components
    always_ff @(posedge aclk) begin
        if (en) begin
            dots_reg.a <= DOT_W'(pa_reg[0]) + DOT_W'(pa_reg[1]) + DOT_W'(pa_reg[2]);
            dots_reg.b <= DOT_W'(pb_reg[0]) + DOT_W'(pb_reg[1]) + DOT_W'(pb_reg[2]);
            dots_reg.c <= DOT_W'(pc_reg[0]) + DOT_W'(pc_reg[1]) + DOT_W'(pc_reg[2]);
            dots_reg.d <= DOT_W'(pd_reg[0]) + DOT_W'(pd_reg[1]) + DOT_W'(pd_reg[2]);
            dots_reg.e <= DOT_W'(pe_reg[0]) + DOT_W'(pe_reg[1]) + DOT_W'(pe_reg[2]);
        end
    end

    assign dots = dots_reg;

endmodule

/* hdl/cpl_wmul.sv */
// Pipelined wide signed multiplier built from 32 x 32 bit limb products, five stages.
// Depends on cpl_pkg.
module cpl_wmul import cpl_pkg::*; #(
    parameter int WA = DOT_W,
    parameter int WB = DOT_W
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int NA = (WA + LIMB_W - 1) / LIMB_W;
    localparam int NB = (WB + LIMB_W - 1) / LIMB_W;
    localparam int SW = (NA + NB) * LIMB_W;

    logic [WA-1:0]          am;
    logic [WB-1:0]          bm;
    logic [NA*LIMB_W-1:0]   ma_reg;
    logic [NB*LIMB_W-1:0]   mb_reg;
    logic [3:0]             neg_reg;
    logic [2*LIMB_W-1:0]    pp_reg   [NA][NB];
    logic [SW-1:0]          row_next [NA];
    logic [SW-1:0]          row_reg  [NA];
    logic [SW-1:0]          sum_next;
    logic [SW-1:0]          sum_reg;
    logic [WA+WB-1:0]       mag;
    logic signed [WA+WB-1:0] p_reg;

    assign am = a[WA-1] ? $unsigned(-a) : $unsigned(a);
    assign bm = b[WB-1] ? $unsigned(-b) : $unsigned(b);

    // Take magnitudes, carry the product sign down the pipe
    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg  <= (NA*LIMB_W)'(am);
            mb_reg  <= (NB*LIMB_W)'(bm);
            neg_reg <= {neg_reg[2:0], a[WA-1] ^ b[WB-1]};
        end
    end

    // Limb products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= ma_reg[i*LIMB_W +: LIMB_W] * mb_reg[j*LIMB_W +: LIMB_W];
                end
            end
        end
    end

    // Row sums: one row per limb of a
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++) begin
                row_next[i] = row_next[i] + (SW'(pp_reg[i][j]) << (j * LIMB_W));
            end
        end
    end

    // Shifted total of the rows
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NA; i++) begin
            sum_next = sum_next + (row_reg[i] << (i * LIMB_W));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            row_reg <= row_next;
            sum_reg <= sum_next;
        end
    end

    // Restore the sign
    assign mag = sum_reg[WA+WB-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= neg_reg[3] ? -$signed(mag) : $signed(mag);
        end
    end

    assign p = p_reg;

endmodule

/* hdl/cpl_div.sv */
// Pipelined restoring divider: trunc(num * 2^FRAC_BITS / den), saturated, zero on den = 0.
// One quotient bit per step stage. Depends on cpl_pkg.
module cpl_div import cpl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  aclk,
    input  logic  en,
    input  wide_t num,
    input  wide_t den,
    output fix_t  quo
);

    localparam int NW = WIDE_W + FRAC_BITS;
    localparam int HW = NW - QUO_BITS;
    localparam int CW = (HW > WIDE_W) ? HW : WIDE_W;
    localparam int RW = WIDE_W + 1;

    typedef struct packed {
        logic ovf;
        logic neg;
        logic dz;
    } dflag_t;

    logic [WIDE_W-1:0]   nm;
    logic [WIDE_W-1:0]   dm;
    logic [NW-1:0]       nmag_reg;
    logic [WIDE_W-1:0]   dmag0_reg;
    logic                neg0_reg;
    logic                dz0_reg;
    logic [HW-1:0]       hi;
    logic                ovf;
    logic [WIDE_W-1:0]   rem_reg  [QUO_BITS+1];
    logic [QUO_BITS-1:0] low_reg  [QUO_BITS+1];
    logic [QUO_BITS-1:0] q_reg    [QUO_BITS+1];
    logic [WIDE_W-1:0]   dmag_reg [QUO_BITS+1];
    dflag_t              flag_reg [QUO_BITS+1];
    logic [QUO_BITS-1:0] q_last;
    dflag_t              f_last;
    fix_t                quo_next;
    fix_t                quo_reg;

    assign nm = num[WIDE_W-1] ? $unsigned(-num) : $unsigned(num);
    assign dm = den[WIDE_W-1] ? $unsigned(-den) : $unsigned(den);

    // Magnitudes, scale the numerator
    always_ff @(posedge aclk) begin
        if (en) begin
            nmag_reg  <= NW'(nm) << FRAC_BITS;
            dmag0_reg <= dm;
            neg0_reg  <= num[WIDE_W-1] ^ den[WIDE_W-1];
            dz0_reg   <= (den == '0);
        end
    end

    // Quotient of 2^QUO_BITS or more saturates; otherwise seed the remainder
    assign hi  = nmag_reg[NW-1:QUO_BITS];
    assign ovf = CW'(hi) >= CW'(dmag0_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= WIDE_W'(hi);
            low_reg[0]  <= nmag_reg[QUO_BITS-1:0];
            q_reg[0]    <= '0;
            dmag_reg[0] <= dmag0_reg;
            flag_reg[0] <= '{ovf: ovf, neg: neg0_reg, dz: dz0_reg};
        end
    end

    // One quotient bit per stage
    for (genvar s = 0; s < QUO_BITS; s++) begin : g_step
        logic [RW-1:0] trial;
        logic          ge;

        assign trial = {rem_reg[s], low_reg[s][QUO_BITS-1]};
        assign ge    = trial >= RW'(dmag_reg[s]);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1]  <= ge ? WIDE_W'(trial - RW'(dmag_reg[s])) : WIDE_W'(trial);
                low_reg[s+1]  <= low_reg[s] << 1;
                q_reg[s+1]    <= {q_reg[s][QUO_BITS-2:0], ge};
                dmag_reg[s+1] <= dmag_reg[s];
                flag_reg[s+1] <= flag_reg[s];
            end
        end
    end

    // Apply sign, saturation and the zero-divisor rule
    assign q_last = q_reg[QUO_BITS];
    assign f_last = flag_reg[QUO_BITS];

    always_comb begin
        if (f_last.dz) begin
            quo_next = '0;
        end else if (!f_last.neg) begin
            quo_next = (f_last.ovf || q_last[QUO_BITS-1]) ? FIX_MAX : fix_t'(q_last);
        end else if (f_last.ovf || (q_last[QUO_BITS-1] && (q_last[QUO_BITS-2:0] != '0))) begin
            quo_next = FIX_MIN;
        end else begin
            quo_next = -$signed(q_last);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

/* hdl/cpl_point.sv */
// Closest points p + t*v for both lines, floored and saturated, two stages.
// Its last register is the block's output register. Depends on cpl_pkg.
module cpl_point import cpl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic en,
    input  in_t  pair,
    input  fix_t t1,
    input  fix_t t2,
    input  logic np,
    output out_t res
);

    fix_t org1 [3];
    fix_t org2 [3];
    fix_t v1   [3];
    fix_t v2   [3];

    logic signed [2*DATA_W-1:0] m1_reg   [3];
    logic signed [2*DATA_W-1:0] m2_reg   [3];
    fix_t                       org1_reg [3];
    fix_t                       org2_reg [3];
    fix_t                       t1_reg;
    fix_t                       t2_reg;
    logic                       np_reg;
    fix_t                       pt1      [3];
    fix_t                       pt2      [3];
    out_t                       res_reg;

    assign org1[0] = pair.first_origin_x;
    assign org1[1] = pair.first_origin_y;
    assign org1[2] = pair.first_origin_z;
    assign v1[0]   = pair.first_dir_x;
    assign v1[1]   = pair.first_dir_y;
    assign v1[2]   = pair.first_dir_z;
    assign org2[0] = pair.second_origin_x;
    assign org2[1] = pair.second_origin_y;
    assign org2[2] = pair.second_origin_z;
    assign v2[0]   = pair.second_dir_x;
    assign v2[1]   = pair.second_dir_y;
    assign v2[2]   = pair.second_dir_z;

    // Products t*v
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                m1_reg[i]   <= t1 * v1[i];
                m2_reg[i]   <= t2 * v2[i];
                org1_reg[i] <= org1[i];
                org2_reg[i] <= org2[i];
            end
            t1_reg <= t1;
            t2_reg <= t2;
            np_reg <= np;
        end
    end

    // Floor to fixed point, add the origin, clamp
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt1[i] = sat_fix((2*DATA_W+1)'(org1_reg[i]) + (2*DATA_W+1)'(m1_reg[i] >>> FRAC_BITS));
            pt2[i] = sat_fix((2*DATA_W+1)'(org2_reg[i]) + (2*DATA_W+1)'(m2_reg[i] >>> FRAC_BITS));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.first_param    <= t1_reg;
            res_reg.second_param   <= t2_reg;
            res_reg.first_point_x  <= pt1[0];
            res_reg.first_point_y  <= pt1[1];
            res_reg.first_point_z  <= pt1[2];
            res_reg.second_point_x <= pt2[0];
            res_reg.second_point_y <= pt2[1];
            res_reg.second_point_z <= pt2[2];
            res_reg.not_parallel   <= np_reg;
        end
    end

    assign res = res_reg;

endmodule

/* hdl/cpl_checker.sv */
// Port-level checks for closest_points_two_lines, attached by bind.
// Depends on cpl_pkg and the top level.
module cpl_checker import cpl_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // No result may be offered in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    // Parallel lines always report a zero first parameter
    a_par_t1: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.not_parallel |-> m_data.first_param == '0)
        else $error("parallel result with nonzero first parameter");

    // While a result is stalled no new transaction enters
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !(s_valid && s_ready))
        else $error("transaction accepted while output stalled");

endmodule

bind closest_points_two_lines cpl_checker u_cpl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
